// ----- rtl/dq_pkg.sv -----
// Shared types and codes for the double-ended queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package dq_pkg;

   localparam int DATA_W = 32;
   localparam int REQ_W = 3;
   localparam int STATUS_W = 2;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_code_type;

   localparam req_code_type REQ_LIST       = 3'd0;
   localparam req_code_type REQ_PUSH_BACK  = 3'd1;
   localparam req_code_type REQ_PUSH_FRONT = 3'd2;
   localparam req_code_type REQ_POP_BACK   = 3'd3;
   localparam req_code_type REQ_POP_FRONT  = 3'd4;

   localparam status_code_type ST_OK    = 2'd0;
   localparam status_code_type ST_EMPTY = 2'd1;
   localparam status_code_type ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            capture;     // latch the accepted request
      logic            push;        // write the held value and move the indices
      logic            pop;         // read the removed entry and move the indices
      logic            list_start;  // start a walk at the front
      logic            list_step;   // advance the walk by one entry
      logic            load_rsp;    // load the result register
      status_code_type rsp_status;
      logic            rsp_use_data; // result value comes from the memory read
      logic            rsp_last;
   } dq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      req_code_type op;
      logic         empty;
      logic         full;
      logic         list_last;
      logic         rsp_free;
   } dq_stat_type;

endpackage

// ----- rtl/dq_req_if.sv -----
// Request channel of the double-ended queue: valid/ready and the request fields.
// Depends on dq_pkg.
interface dq_req_if import dq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   req_code_type             req_type;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink (input valid, input req_type, input value, output ready);
endinterface

// ----- rtl/dq_rsp_if.sv -----
// Result channel of the double-ended queue: valid/ready and the result fields.
// Depends on dq_pkg.
interface dq_rsp_if import dq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_code_type          status;
   logic signed [DATA_W-1:0] value_res;
   logic                     last;

   modport source (output valid, output status, output value_res, output last, input ready);
   modport sink (input valid, input status, input value_res, input last, output ready);
endinterface

// ----- rtl/dq_ctrl.sv -----
// Controller state machine of the double-ended queue.
// Depends on dq_pkg; drives the datapath through dq_cmd_type commands.
module dq_ctrl import dq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dq_stat_type stat,
   output dq_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_EXEC     = 2'd1;
   localparam logic [1:0] S_POP_OUT  = 2'd2;
   localparam logic [1:0] S_LIST_OUT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.op) inside
               REQ_LIST: begin
                  if (!stat.empty) begin
                     cmd.list_start = 1'b1;
                     state_in = S_LIST_OUT;
                  end else if (stat.rsp_free) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     cmd.rsp_last = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                  // The write waits for the result slot so both happen together.
                  if (stat.rsp_free) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_last = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               REQ_POP_BACK, REQ_POP_FRONT: begin
                  if (!stat.empty) begin
                     cmd.pop = 1'b1;
                     state_in = S_POP_OUT;
                  end else if (stat.rsp_free) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     cmd.rsp_last = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_POP_OUT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_use_data = 1'b1;
               cmd.rsp_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LIST_OUT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_use_data = 1'b1;
               cmd.rsp_last = stat.list_last;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.list_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/dq_datapath.sv -----
// Datapath of the double-ended queue: ring memory, front index, fill count,
// list walker and the result register. Depends on dq_pkg; commanded by dq_ctrl.
module dq_datapath import dq_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dq_cmd_type               cmd,
   output dq_stat_type              stat,
   input  req_code_type             req_type,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output status_code_type          rsp_status,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic                     rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0]  front_ff;
   logic [CNT_W-1:0]  count_ff;
   req_code_type      op_ff;
   logic [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]  walk_ff;
   logic [CNT_W-1:0]  left_ff;
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              rsp_valid_ff;
   status_code_type   rsp_status_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_last_ff;

   logic [IDX_W-1:0] front_prev;
   logic [IDX_W-1:0] front_next;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] pop_addr;
   logic [IDX_W-1:0] walk_next;
   logic             mem_re;

   // Ring addition; both operands keep the sum below twice the depth.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   assign front_prev = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_next = ring_add(front_ff, CNT_W'(1));
   assign walk_next  = ring_add(walk_ff, CNT_W'(1));
   assign pop_addr   = (op_ff == REQ_POP_BACK) ? ring_add(front_ff, count_ff - 1'b1)
                                               : front_ff;
   assign wr_addr    = (op_ff == REQ_PUSH_BACK) ? ring_add(front_ff, count_ff) : front_prev;

   always_comb begin
      if (cmd.pop) begin
         rd_addr = pop_addr;
      end else if (cmd.list_start) begin
         rd_addr = front_ff;
      end else begin
         rd_addr = walk_next;
      end
   end

   assign mem_re = cmd.pop | cmd.list_start | cmd.list_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.push) begin
         if (op_ff == REQ_PUSH_FRONT) begin
            front_ff <= front_prev;
         end
         count_ff <= count_ff + 1'b1;
      end else if (cmd.pop) begin
         if (op_ff == REQ_POP_FRONT) begin
            front_ff <= front_next;
         end
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_type;
         value_ff <= req_value;
      end
      if (cmd.list_start) begin
         walk_ff <= front_ff;
         left_ff <= count_ff;
      end else if (cmd.list_step) begin
         walk_ff <= walk_next;
         left_ff <= left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= value_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= cmd.rsp_use_data ? rd_data_ff : '0;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   assign stat.op        = op_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.list_last = (left_ff == CNT_W'(1));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- rtl/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values in a DEPTH-entry ring memory.
// A request item on req_bus carries req_type and value: list all, push back,
// push front, pop back or pop front. Every served request returns one or more
// result items on rsp_bus with status, value_res and last; the final result of a
// request has last set. Unused request codes are dropped without a result.
// Timing: a request is taken in S_IDLE and executed in the next cycle, in S_EXEC.
// A push (or any empty or full answer) loads its result in S_EXEC; a pop loads
// it in S_POP_OUT, since the memory read is registered. A list reads its first
// entry in S_EXEC, shows it from S_LIST_OUT and then one result per cycle while
// the receiver takes them, paced by the single memory read port. The next
// request is accepted in the cycle after the final result is loaded, while that
// result may still wait: a push passes S_IDLE and S_EXEC, a pop also S_POP_OUT.
// Reset clears the front index, the fill count, the controller and the result
// valid; the memory is not cleared and needs no clearing pass.
// When the receiver holds rsp_bus.ready low, the result register holds and the
// controller waits with the next result, so no item is lost or repeated.
// Depends on dq_pkg, dq_req_if, dq_rsp_if, dq_ctrl and dq_datapath.
module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH = 32
) (
   input logic      clock,
   input logic      reset,
   dq_req_if.sink   req_bus,
   dq_rsp_if.source rsp_bus
);

   dq_cmd_type  cmd;
   dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_bus.req_type),
      .req_value  (req_bus.value),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_status (rsp_bus.status),
      .rsp_value  (rsp_bus.value_res),
      .rsp_last   (rsp_bus.last)
   );

endmodule

// ----- tb/sv/double_ended_queue_tb.sv -----
// Self-checking testbench for the double-ended queue: a directed table, then random traffic.
// A behavioral deque model predicts the result items in order, except where a typed row gives its own.
// Depends on dq_pkg, dq_req_if, dq_rsp_if and the double_ended_queue top level.
module double_ended_queue_tb import dq_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 32;
   localparam int RANDOM_ITEMS = 135;
   localparam int CALM_ITEMS   = 40;
   localparam int PHASE_ITEMS  = 60;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 40;

   // Request codes the block drops without a result.
   localparam req_code_type REQ_SPARE_LO  = 3'd5;
   localparam req_code_type REQ_SPARE_MID = 3'd6;
   localparam req_code_type REQ_SPARE_HI  = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_NEG1  = -32'sd1;
   localparam logic signed [DATA_W-1:0] VAL_ZERO  = 32'sd0;
   localparam logic signed [DATA_W-1:0] VAL_JUNK  = 32'sh5A5A_5A5A;
   localparam logic signed [DATA_W-1:0] FILL_BASE = 32'sh0000_1000;
   localparam logic signed [DATA_W-1:0] REFILL_BASE = 32'sh0000_2000;

   typedef struct {
      status_code_type          status;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } rsp_item_type;

   typedef struct packed {
      req_code_type             op;
      logic signed [DATA_W-1:0] value;
      logic [7:0]               reps;
      logic                     typed;
      status_code_type          status;
      logic signed [DATA_W-1:0] exp_value;
   } stim_row_type;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   // A row with typed set carries its one expected result; the rest use the model.
   // Values of repeated rows count up from the given one.
   localparam stim_row_type DIRECTED [25] = '{
      '{REQ_LIST,       VAL_ZERO,    8'd1,  1'b1, ST_EMPTY, VAL_ZERO},
      '{REQ_POP_BACK,   VAL_JUNK,    8'd1,  1'b1, ST_EMPTY, VAL_ZERO},
      '{REQ_POP_FRONT,  VAL_JUNK,    8'd1,  1'b1, ST_EMPTY, VAL_ZERO},
      '{REQ_SPARE_LO,   VAL_JUNK,    8'd1,  1'b0, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_BACK,  VAL_MAX,     8'd1,  1'b1, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_FRONT, VAL_MIN,     8'd1,  1'b1, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_BACK,  VAL_ZERO,    8'd1,  1'b1, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_FRONT, VAL_NEG1,    8'd1,  1'b1, ST_OK,    VAL_ZERO},
      '{REQ_LIST,       VAL_JUNK,    8'd1,  1'b0, ST_OK,    VAL_ZERO},
      '{REQ_POP_FRONT,  VAL_JUNK,    8'd1,  1'b1, ST_OK,    VAL_NEG1},
      '{REQ_POP_BACK,   VAL_JUNK,    8'd1,  1'b1, ST_OK,    VAL_ZERO},
      '{REQ_POP_BACK,   VAL_JUNK,    8'd1,  1'b1, ST_OK,    VAL_MAX},
      '{REQ_POP_FRONT,  VAL_JUNK,    8'd1,  1'b1, ST_OK,    VAL_MIN},
      '{REQ_POP_FRONT,  VAL_JUNK,    8'd1,  1'b1, ST_EMPTY, VAL_ZERO},
      '{REQ_SPARE_MID,  VAL_MAX,     8'd1,  1'b0, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_FRONT, FILL_BASE,   8'd32, 1'b0, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_BACK,  VAL_JUNK,    8'd1,  1'b1, ST_FULL,  VAL_ZERO},
      '{REQ_PUSH_FRONT, VAL_JUNK,    8'd1,  1'b1, ST_FULL,  VAL_ZERO},
      '{REQ_LIST,       VAL_ZERO,    8'd1,  1'b0, ST_OK,    VAL_ZERO},
      '{REQ_POP_BACK,   VAL_JUNK,    8'd16, 1'b0, ST_OK,    VAL_ZERO},
      '{REQ_PUSH_BACK,  REFILL_BASE, 8'd16, 1'b0, ST_OK,    VAL_ZERO},
      '{REQ_LIST,       VAL_ZERO,    8'd1,  1'b0, ST_OK,    VAL_ZERO},
      '{REQ_POP_FRONT,  VAL_JUNK,    8'd32, 1'b0, ST_OK,    VAL_ZERO},
      '{REQ_LIST,       VAL_MIN,     8'd1,  1'b1, ST_EMPTY, VAL_ZERO},
      '{REQ_SPARE_HI,   VAL_NEG1,    8'd1,  1'b0, ST_OK,    VAL_ZERO}
   };

   logic clock = 1'b0;
   logic reset;

   dq_req_if req_bus ();
   dq_rsp_if rsp_bus ();

   double_ended_queue #(.DEPTH(DEPTH)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Deque model state and the results it still owes.
   logic signed [DATA_W-1:0] model_slot [DEPTH];
   int           model_front = 0;
   int           model_count = 0;
   rsp_item_type due_results [$];

   int mismatches   = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   bit calm         = 1'b0;

   function automatic rsp_item_type make_rsp(input status_code_type status,
                                             input logic signed [DATA_W-1:0] value,
                                             input logic last);
      rsp_item_type item;
      item.status = status;
      item.value  = value;
      item.last   = last;
      return item;
   endfunction

   task automatic apply_to_deque(input req_code_type op, input logic signed [DATA_W-1:0] value);
      int slot;
      case (op)
         REQ_LIST: begin
            if (model_count == 0) begin
               due_results.push_back(make_rsp(ST_EMPTY, VAL_ZERO, 1'b1));
            end else begin
               for (int i = 0; i < model_count; i++) begin
                  due_results.push_back(make_rsp(ST_OK, model_slot[(model_front + i) % DEPTH],
                                                 i == model_count - 1));
               end
            end
         end
         REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
            if (model_count == DEPTH) begin
               due_results.push_back(make_rsp(ST_FULL, VAL_ZERO, 1'b1));
            end else begin
               if (op == REQ_PUSH_BACK) begin
                  slot = (model_front + model_count) % DEPTH;
               end else begin
                  slot = (model_front + DEPTH - 1) % DEPTH;
                  model_front = slot;
               end
               model_slot[slot] = value;
               model_count++;
               due_results.push_back(make_rsp(ST_OK, VAL_ZERO, 1'b1));
            end
         end
         REQ_POP_BACK, REQ_POP_FRONT: begin
            if (model_count == 0) begin
               due_results.push_back(make_rsp(ST_EMPTY, VAL_ZERO, 1'b1));
            end else begin
               if (op == REQ_POP_BACK) begin
                  slot = (model_front + model_count - 1) % DEPTH;
               end else begin
                  slot = model_front;
                  model_front = (model_front + 1) % DEPTH;
               end
               model_count--;
               due_results.push_back(make_rsp(ST_OK, model_slot[slot], 1'b1));
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatches++;
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
   endtask

   task automatic check_result();
      rsp_item_type want;
      results_seen++;
      if (due_results.size() == 0) begin
         report_mismatch("unexpected item, value", rsp_bus.value_res, VAL_ZERO);
         return;
      end
      want = due_results.pop_front();
      if (rsp_bus.status !== want.status) begin
         report_mismatch("status", DATA_W'(rsp_bus.status), DATA_W'(want.status));
      end
      if (rsp_bus.value_res !== want.value) report_mismatch("value", rsp_bus.value_res, want.value);
      if (rsp_bus.last !== want.last) begin
         report_mismatch("last", DATA_W'(rsp_bus.last), DATA_W'(want.last));
      end
   endtask

   // Called at a rising edge. The handshake is sampled before the edge's updates land,
   // so ready seen here is the value the block had at that edge.
   task automatic send_request(input req_code_type op, input logic signed [DATA_W-1:0] value);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= op;
      req_bus.value    <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_to_deque(op, value);
   endtask

   task automatic sender_gap(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic req_code_type pick_op(input traffic_mode_type mode);
      int roll;
      int push_below;
      roll = $urandom_range(0, 99);
      if (roll < 4) return REQ_SPARE_LO + req_code_type'($urandom_range(0, 2));
      if (roll < 10) return REQ_LIST;
      case (mode)
         MODE_FILL:  push_below = 85;
         MODE_DRAIN: push_below = 25;
         default:    push_below = 55;
      endcase
      if (roll < push_below) return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return VAL_ZERO;
         3:       return VAL_NEG1;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      req_code_type     op;
      traffic_mode_type mode;
      int               served;
      int               phase_left;
      bit               gappy;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_LIST;
      req_bus.value    = VAL_ZERO;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++) begin
         for (int k = 0; k < DIRECTED[r].reps; k++) begin
            send_request(DIRECTED[r].op, DIRECTED[r].value + k);
            if (DIRECTED[r].typed) begin
               due_results[due_results.size() - 1] =
                  make_rsp(DIRECTED[r].status, DIRECTED[r].exp_value, 1'b1);
            end
         end
      end

      // Random traffic in phases that lean toward filling, draining or neither.
      served     = 0;
      phase_left = 0;
      mode       = MODE_MIXED;
      gappy      = 1'b0;
      while (served < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            mode       = traffic_mode_type'($urandom_range(0, 2));
            phase_left = PHASE_ITEMS;
            gappy      = $urandom_range(0, 1);
         end
         if (served >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         op = pick_op(mode);
         if (!calm && gappy && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 14));
         send_request(op, pick_value());
         if (op <= REQ_POP_FRONT) begin
            served++;
            phase_left--;
         end
      end
      req_bus.valid <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Result side: checks each accepted item and decides ready for the next edge.
   initial begin : receiver
      int hold_left;
      int burst_left;
      int window_left;
      bit hold_done;
      bit noisy;
      hold_left     = 0;
      burst_left    = 0;
      window_left   = 0;
      hold_done     = 1'b0;
      noisy         = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_result();
         // One long hold-off makes the block back up and stall its request side.
         if (!hold_done && results_seen == HOLD_AFTER) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (window_left == 0) begin
            window_left = 64;
            noisy       = $urandom_range(0, 1);
         end
         window_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && noisy && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 14) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

endmodule
